// ===== rtl/core/icfa_pkg.sv =====
package icfa_pkg;

  localparam int unsigned MaxTimings = 1024;
  localparam int unsigned AddrW      = $clog2(MaxTimings);
  localparam int unsigned CountW     = AddrW + 1;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgWindowFraction = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMinWindow      = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinMarkCount   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFadeRatioLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMarkDropFactor = 3'd4;

  // Datapath operations requested by the controller.
  typedef enum logic [3:0] {
    OpNone    = 4'd0,
    OpStore   = 4'd1,
    OpSetup   = 4'd2,
    OpWinAddr = 4'd3,
    OpWinAcc  = 4'd4,
    OpDivInit = 4'd5,
    OpDivStep = 4'd6,
    OpScanAdr = 4'd7,
    OpScanChk = 4'd8,
    OpFinish  = 4'd9
  } op_e;

  // Which quotient the shared divider produces.
  typedef enum logic [1:0] {
    DivHead  = 2'd0,
    DivTail  = 2'd1,
    DivRatio = 2'd2
  } div_sel_e;

  typedef struct packed {
    op_e      op;
    div_sel_e div_sel;
    logic     tail_pass;
  } cmd_t;

  typedef struct packed {
    logic short_cap;
    logic few_marks;
    logic no_ratio;
    logic win_done;
    logic div_done;
    logic scan_done;
    logic no_window;
  } status_t;

  typedef struct packed {
    logic [8:0]  mark_count;
    logic [23:0] head_mean;
    logic [23:0] tail_mean;
    logic [23:0] tail_head_ratio;
    logic        faded;
    logic [25:0] fade_onset_us;
  } result_t;

  localparam int unsigned ResultDataW = 112;

endpackage

// ===== rtl/core/icfa_datapath.sv =====
module icfa_datapath import icfa_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  input  logic [15:0]      timing_i,
  input  logic [15:0]      window_fraction_i,
  input  logic [10:0]      min_window_i,
  input  logic [10:0]      min_mark_count_i,
  input  logic [15:0]      fade_ratio_limit_i,
  input  logic [15:0]      mark_drop_factor_i,
  output status_t          status_o,
  output result_t          result_o
);

  logic [15:0] mem_q [MaxTimings];
  logic [15:0] rdata_q;
  logic [AddrW-1:0] raddr;

  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] len_q, len_d;
  logic [CountW-1:0] marks_q, marks_d;
  logic [CountW-1:0] win_q, win_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic [26:0] hs_q, hs_d, ts_q, ts_d;
  logic [25:0] elapsed_q, elapsed_d;
  logic [25:0] onset_q, onset_d;
  logic        found_q, found_d;
  logic [42:0] rem_q, rem_d;
  logic [42:0] quo_q, quo_d;
  logic [42:0] dvs_q, dvs_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic [23:0] hm_q, hm_d, tm_q, tm_d, ratio_q, ratio_d;
  logic        faded_q, faded_d;
  logic [42:0] lhs_q, lhs_d, rhs_q, rhs_d;
  logic        is_mark_q, is_mark_d;
  logic [26:0] wide_mark;

  logic [27:0] win_prod;
  logic [CountW-1:0] win_raw, win_lo;
  logic [CountW-1:0] marks_calc;
  logic [AddrW:0] mark_idx;
  logic [43:0] rem_sh;

  assign marks_calc = (len_q >= CountW'(4)) ? CountW'((len_q - CountW'(2)) >> 1) : '0;
  assign win_prod   = 28'(marks_calc) * 28'(window_fraction_i);
  assign win_raw    = CountW'(win_prod >> 16);
  assign win_lo     = (win_raw < CountW'(min_window_i)) ? CountW'(min_window_i) : win_raw;

  // Mark index for the head or tail walk.
  assign mark_idx = cmd_i.tail_pass ? CountW'(marks_q - win_q + idx_q) : idx_q;

  always_comb begin
    raddr = '0;
    if (cmd_i.op == OpWinAddr) begin
      raddr = AddrW'(CountW'(2) + (CountW'(mark_idx) << 1));
    end else if (cmd_i.op == OpScanAdr) begin
      raddr = idx_q[AddrW-1:0];
    end
  end

  // The read word is held until the next address command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OpStore && count_q < CountW'(MaxTimings)) begin
      mem_q[count_q[AddrW-1:0]] <= timing_i;
    end
    if (cmd_i.op == OpWinAddr || cmd_i.op == OpScanAdr) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign rem_sh    = {rem_q, quo_q[42]};
  assign wide_mark = 27'(rdata_q);

  always_comb begin
    count_d = count_q; len_d = len_q; marks_d = marks_q; win_d = win_q;
    idx_d = idx_q; hs_d = hs_q; ts_d = ts_q; elapsed_d = elapsed_q;
    onset_d = onset_q; found_d = found_q; rem_d = rem_q; quo_d = quo_q;
    dvs_d = dvs_q; dcnt_d = dcnt_q; hm_d = hm_q; tm_d = tm_q;
    ratio_d = ratio_q; faded_d = faded_q; lhs_d = lhs_q; rhs_d = rhs_q;
    is_mark_d = is_mark_q;
    unique case (cmd_i.op)
      OpStore: begin
        if (count_q < CountW'(MaxTimings)) begin
          count_d = count_q + CountW'(1);
          len_d   = count_q + CountW'(1);
        end else begin
          len_d = count_q;
        end
      end
      OpSetup: begin
        count_d = '0;
        marks_d = marks_calc;
        win_d = (win_lo > marks_calc) ? marks_calc : win_lo;
        hs_d = '0; ts_d = '0; idx_d = '0; hm_d = '0; tm_d = '0;
        ratio_d = '0; faded_d = 1'b0; onset_d = '0; elapsed_d = '0;
        found_d = 1'b0;
      end
      OpWinAcc: begin
        if (cmd_i.tail_pass) ts_d = ts_q + wide_mark;
        else                 hs_d = hs_q + wide_mark;
        idx_d = (idx_q + CountW'(1) == win_q) ? '0 : idx_q + CountW'(1);
      end
      OpDivInit: begin
        rem_d  = '0;
        dcnt_d = '0;
        unique case (cmd_i.div_sel)
          DivHead:  begin quo_d = 43'(hs_q) << 8;  dvs_d = 43'(win_q); end
          DivTail:  begin quo_d = 43'(ts_q) << 8;  dvs_d = 43'(win_q); end
          default:  begin quo_d = 43'(ts_q) << 16; dvs_d = 43'(hs_q); end
        endcase
        lhs_d = 43'(ts_q) << 16;
        rhs_d = 43'(fade_ratio_limit_i) * 43'(hs_q);
      end
      OpDivStep: begin
        if (rem_sh >= {1'b0, dvs_q}) begin
          rem_d = 43'(rem_sh - {1'b0, dvs_q});
          quo_d = {quo_q[41:0], 1'b1};
        end else begin
          rem_d = rem_sh[42:0];
          quo_d = {quo_q[41:0], 1'b0};
        end
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd42) begin
          unique case (cmd_i.div_sel)
            DivHead: hm_d = quo_d[23:0];
            DivTail: tm_d = quo_d[23:0];
            default: begin
              ratio_d = (quo_d[42:24] != '0) ? 24'hFFFFFF : quo_d[23:0];
              faded_d = (marks_q >= CountW'(min_mark_count_i)) && (lhs_q < rhs_q);
            end
          endcase
        end
      end
      OpScanAdr: begin
        is_mark_d = (idx_q >= CountW'(2)) && !idx_q[0] && (idx_q + CountW'(1) < len_q);
        rhs_d = 43'(mark_drop_factor_i) * 43'(hs_q);
      end
      OpScanChk: begin
        lhs_d = (43'(rdata_q) << 16) * 43'(win_q);
        if (is_mark_q && ((43'(rdata_q) << 16) * 43'(win_q) < rhs_q)) begin
          found_d = 1'b1;
          onset_d = elapsed_q;
        end else begin
          elapsed_d = elapsed_q + 26'(rdata_q);
        end
        idx_d = idx_q + CountW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0; len_q <= '0; marks_q <= '0; win_q <= '0; idx_q <= '0;
      hs_q <= '0; ts_q <= '0; elapsed_q <= '0; onset_q <= '0; found_q <= 1'b0;
      dcnt_q <= '0; hm_q <= '0; tm_q <= '0; ratio_q <= '0; faded_q <= 1'b0;
      is_mark_q <= 1'b0;
    end else begin
      count_q <= count_d; len_q <= len_d; marks_q <= marks_d; win_q <= win_d;
      idx_q <= idx_d; hs_q <= hs_d; ts_q <= ts_d; elapsed_q <= elapsed_d;
      onset_q <= onset_d; found_q <= found_d; dcnt_q <= dcnt_d; hm_q <= hm_d;
      tm_q <= tm_d; ratio_q <= ratio_d; faded_q <= faded_d; is_mark_q <= is_mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d; lhs_q <= lhs_d; rhs_q <= rhs_d;
  end

  assign status_o.short_cap = (len_q < CountW'(4));
  assign status_o.few_marks = (marks_q < CountW'(2));
  assign status_o.no_ratio  = (win_q == '0) || (hs_q == '0);
  assign status_o.win_done  = (idx_q + CountW'(1) == win_q);
  assign status_o.div_done  = (dcnt_q == 6'd42);
  assign status_o.scan_done = found_q || (idx_q >= len_q);
  assign status_o.no_window = (win_q == '0);

  assign result_o.mark_count      = marks_q[8:0];
  assign result_o.head_mean       = hm_q;
  assign result_o.tail_mean       = tm_q;
  assign result_o.tail_head_ratio = ratio_q;
  assign result_o.faded           = faded_q;
  assign result_o.fade_onset_us   = onset_q;

endmodule

// ===== rtl/core/icfa_ctrl.sv =====
module icfa_ctrl import icfa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_last_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StSetup = 10'b0000000010,
    StWAddr = 10'b0000000100,
    StWRead = 10'b0000001000,
    StWAcc  = 10'b0000010000,
    StDInit = 10'b0000100000,
    StDStep = 10'b0001000000,
    StSAddr = 10'b0010000000,
    StSChk  = 10'b0100000000,
    StOut   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic tail_q, tail_d;
  div_sel_e sel_q, sel_d;
  logic wait_q, wait_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q; tail_d = tail_q; sel_d = sel_q; wait_d = wait_q;
    cmd_o.op = OpNone; cmd_o.div_sel = sel_q; cmd_o.tail_pass = tail_q;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_o.op = OpStore;
        if (in_last_i) state_d = StSetup;
      end
      StSetup: begin
        cmd_o.op = OpSetup;
        tail_d = 1'b0;
        state_d = StWAddr;
      end
      StWAddr: begin
        if (status_i.short_cap || status_i.few_marks || status_i.no_window) begin
          state_d = StOut;
        end else begin
          cmd_o.op = OpWinAddr;
          state_d = StWRead;
        end
      end
      StWRead: begin
        state_d = StWAcc;
      end
      StWAcc: begin
        cmd_o.op = OpWinAcc;
        if (status_i.win_done) begin
          if (tail_q) begin
            sel_d = DivHead;
            state_d = StDInit;
          end else begin
            tail_d = 1'b1;
            state_d = StWAddr;
          end
        end else begin
          state_d = StWAddr;
        end
      end
      StDInit: begin
        cmd_o.op = OpDivInit;
        state_d = StDStep;
      end
      StDStep: begin
        cmd_o.op = OpDivStep;
        if (status_i.div_done) begin
          unique case (sel_q)
            DivHead: begin sel_d = DivTail; state_d = StDInit; end
            DivTail: begin
              if (status_i.no_ratio) state_d = StOut;
              else begin sel_d = DivRatio; state_d = StDInit; end
            end
            default: begin wait_d = 1'b1; state_d = StSAddr; end
          endcase
        end
      end
      StSAddr: begin
        if (status_i.scan_done && !wait_q) begin
          state_d = StOut;
        end else begin
          wait_d = 1'b0;
          cmd_o.op = OpScanAdr;
          state_d = StSChk;
        end
      end
      StSChk: begin
        cmd_o.op = OpScanChk;
        state_d = StSAddr;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; tail_q <= 1'b0; sel_q <= DivHead; wait_q <= 1'b0;
    end else begin
      state_q <= state_d; tail_q <= tail_d; sel_q <= sel_d; wait_q <= wait_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accepts while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
`endif

endmodule

// ===== rtl/core/ir_capture_fade_analyser.sv =====
// Collects one infrared capture of 16-bit microsecond timings, one word per
// cycle, into a 1024-entry store; words past 1024 are dropped. On the word
// with tlast the block stops taking input and analyses the capture: a walk
// over head and tail windows (address, read, accumulate for each mark), up to
// three 43-step restoring divisions for the means and the ratio, and a scan
// over the stored timings (address, check) until the onset is found or the
// timings run out. One result word then waits on the output until taken.
module ir_capture_fade_analyser import icfa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [15:0]            s_axis_tdata,  // timing_us
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // mark_count, head_mean, tail_mean, tail_head_ratio, faded, fade_onset_us
  output logic [ResultDataW-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i
);

  logic [15:0] wf_q, frl_q, mdf_q;
  logic [10:0] mw_q, mmc_q;
  cmd_t    cmd;
  status_t status;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wf_q <= 16'd16384; mw_q <= 11'd4; mmc_q <= 11'd8;
      frl_q <= 16'd45875; mdf_q <= 16'd32768;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWindowFraction: wf_q  <= cfg_data_i;
        CfgMinWindow:      mw_q  <= cfg_data_i[10:0];
        CfgMinMarkCount:   mmc_q <= cfg_data_i[10:0];
        CfgFadeRatioLimit: frl_q <= cfg_data_i;
        CfgMarkDropFactor: mdf_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  icfa_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_last_i(s_axis_tlast), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .status_i(status), .cmd_o(cmd)
  );

  icfa_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .timing_i(s_axis_tdata),
    .window_fraction_i(wf_q), .min_window_i(mw_q), .min_mark_count_i(mmc_q),
    .fade_ratio_limit_i(frl_q), .mark_drop_factor_i(mdf_q),
    .status_o(status), .result_o(res)
  );

  assign m_axis_tdata = {4'b0000, res.fade_onset_us, res.faded, res.tail_head_ratio,
                         res.tail_mean, res.head_mean, res.mark_count};

endmodule
